// ===== hw/rtl/dmx_to_pixel_mapper_top_defines.svh =====
// Assertion macros for the DMX to pixel mapper.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DMX_TO_PIXEL_MAPPER_TOP_DEFINES_SVH
`define DMX_TO_PIXEL_MAPPER_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define DTPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DTPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dtpm_pkg.sv =====
// Shared types and constants for the DMX to pixel mapper.
// No dependencies.
`timescale 1ns / 1ps

package dtpm_pkg;

	localparam int MAX_OUTPUTS        = 8;
	localparam int MAX_UNIVERSE_SLOTS = 4;
	localparam int FRAME_BYTES        = 512;
	localparam int MAX_GROUPING       = 64;
	localparam int POS_LIMIT          = 8191;
	localparam int PIXEL_LIMIT        = 4095;
	localparam int BEGIN_W            = 12;

	localparam logic [12:0] FRAME_PIX3 = 13'(FRAME_BYTES / 3);
	localparam logic [12:0] FRAME_PIX4 = 13'(FRAME_BYTES / 4);

	typedef enum logic [2:0] {
		REG_CPP         = 3'd0,
		REG_COLOR_MAP   = 3'd1,
		REG_UNIVERSES   = 3'd2,
		REG_GROUP_COUNT = 3'd3,
		REG_GROUPING    = 3'd4,
		REG_LAST_PORT   = 3'd5,
		REG_BEGIN_TABLE = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		MAP_RGB = 3'd0,
		MAP_RBG = 3'd1,
		MAP_GRB = 3'd2,
		MAP_GBR = 3'd3,
		MAP_BRG = 3'd4,
		MAP_BGR = 3'd5
	} color_map_t;

	typedef struct packed {
		logic [2:0]  cpp;
		logic [2:0]  color_map;
		logic [2:0]  universes;
		logic [12:0] group_count;
		logic [6:0]  grouping;
		logic [4:0]  last_port;
		logic [47:0] begin_table;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cpp:         3'd3,
		color_map:   3'd0,
		universes:   3'd1,
		group_count: 13'd170,
		grouping:    7'd1,
		last_port:   5'd0,
		begin_table: 48'd0
	};

	typedef struct packed {
		logic accept;
		logic mul;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic any;
		logic last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/dtpm_datapath.sv =====
// Datapath: pixel assembly, color mapping, group position, write expansion
// and output register. Depends on dtpm_pkg.
`timescale 1ns / 1ps

module dtpm_datapath
	import dtpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [4:0]  port_index,
	input  logic [7:0]  channel_byte,
	input  logic        frame_first,
	input  logic        frame_last,
	input  logic        want_update,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [2:0]  output_number,
	output logic [11:0] pixel_number,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	output logic        update_strobe,
	output logic        run_last
);

	logic [1:0]  phase_q;
	logic [7:0]  bytes_q [3];
	logic [12:0] gp_q;

	logic [7:0]  col_q [4];
	logic [2:0]  outno_q;
	logic        go_q;
	logic        strobe_q;
	logic [12:0] gmul_q;
	logic [6:0]  grp_q;
	logic [19:0] pix_q;
	logic [6:0]  k_q;

	logic        out_valid_q;
	logic        wv_q;
	logic [2:0]  outno_out_q;
	logic [11:0] pix_out_q;
	logic [7:0]  col_out_q [4];
	logic        strobe_out_q;
	logic        last_out_q;

	logic [2:0]  uni;
	logic [4:0]  quo;
	logic [4:0]  rem;
	logic [11:0] begin_idx;
	logic [6:0]  grp;
	logic        cpp3;
	logic [1:0]  phase_eff;
	logic [12:0] gp_eff;
	logic        pix_done;
	logic [7:0]  col [4];
	logic        ok;
	logic        strobe;
	logic        has_write;

	always_comb begin
		if (cfg.universes == 3'd0) begin
			uni = 3'd1;
		end else if (cfg.universes > 3'(MAX_UNIVERSE_SLOTS)) begin
			uni = 3'(MAX_UNIVERSE_SLOTS);
		end else begin
			uni = cfg.universes;
		end
		unique case (uni)
			3'd1:    quo = port_index;
			3'd2:    quo = port_index >> 1;
			3'd3:    quo = 5'((10'(port_index) * 10'd11) >> 5);
			3'd4:    quo = port_index >> 2;
			default: quo = port_index;
		endcase
		rem = port_index - 5'(quo * 5'(uni));
		begin_idx = cfg.begin_table[BEGIN_W * rem[1:0] +: BEGIN_W];
		grp = (cfg.grouping > 7'(MAX_GROUPING)) ? 7'(MAX_GROUPING) : cfg.grouping;
		cpp3 = (cfg.cpp == 3'd3);
		phase_eff = frame_first ? 2'd0 : phase_q;
		gp_eff = frame_first ? {1'b0, begin_idx} : gp_q;
		pix_done = ({1'b0, phase_eff} + 3'd1) >= (cpp3 ? 3'd3 : 3'd4);
		col[3] = 8'd0;
		if (cpp3) begin
			unique case (color_map_t'(cfg.color_map))
				MAP_RBG: begin
					col[0] = bytes_q[0]; col[1] = channel_byte; col[2] = bytes_q[1];
				end
				MAP_GRB: begin
					col[0] = bytes_q[1]; col[1] = bytes_q[0]; col[2] = channel_byte;
				end
				MAP_GBR: begin
					col[0] = channel_byte; col[1] = bytes_q[0]; col[2] = bytes_q[1];
				end
				MAP_BRG: begin
					col[0] = bytes_q[1]; col[1] = channel_byte; col[2] = bytes_q[0];
				end
				MAP_BGR: begin
					col[0] = channel_byte; col[1] = bytes_q[1]; col[2] = bytes_q[0];
				end
				default: begin
					col[0] = bytes_q[0]; col[1] = bytes_q[1]; col[2] = channel_byte;
				end
			endcase
		end else begin
			col[0] = bytes_q[0];
			col[1] = bytes_q[1];
			col[2] = bytes_q[2];
			col[3] = channel_byte;
		end
		ok = (gp_eff < cfg.group_count)
			&& !((gp_eff >= {1'b0, begin_idx})
				&& ((gp_eff - {1'b0, begin_idx}) >= (cpp3 ? FRAME_PIX3 : FRAME_PIX4)))
			&& (quo < 5'(MAX_OUTPUTS));
		strobe = frame_last && want_update && (port_index == cfg.last_port);
		has_write = go_q && (pix_q <= 20'(PIXEL_LIMIT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			gp_q <= 13'd0;
			for (int i = 0; i < 3; i++) begin
				bytes_q[i] <= 8'd0;
			end
		end else if (cmd.accept) begin
			if (pix_done) begin
				phase_q <= 2'd0;
				gp_q <= (gp_eff < 13'(POS_LIMIT)) ? gp_eff + 13'd1 : gp_eff;
			end else begin
				bytes_q[phase_eff] <= channel_byte;
				phase_q <= frame_last ? 2'd0 : phase_eff + 2'd1;
				gp_q <= gp_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q <= col;
			outno_q <= quo[2:0];
			go_q <= pix_done && ok && (grp != 7'd0);
			strobe_q <= strobe;
			gmul_q <= gp_eff;
			grp_q <= grp;
		end
		if (cmd.mul) begin
			pix_q <= 20'(gmul_q) * 20'(grp_q);
			k_q <= 7'd0;
		end else if (cmd.load && has_write) begin
			pix_q <= pix_q + 20'd1;
			k_q <= k_q + 7'd1;
		end
	end

	assign sts.any = has_write || strobe_q;
	assign sts.last = !has_write || (7'(k_q + 7'd1) == grp_q)
		|| (pix_q == 20'(PIXEL_LIMIT));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wv_q <= has_write;
			outno_out_q <= has_write ? outno_q : 3'd0;
			pix_out_q <= has_write ? pix_q[11:0] : 12'd0;
			for (int i = 0; i < 4; i++) begin
				col_out_q[i] <= has_write ? col_q[i] : 8'd0;
			end
			strobe_out_q <= strobe_q && sts.last;
			last_out_q <= sts.last;
		end
	end

	assign out_valid = out_valid_q;
	assign write_valid = wv_q;
	assign output_number = outno_out_q;
	assign pixel_number = pix_out_q;
	assign red = col_out_q[0];
	assign green = col_out_q[1];
	assign blue = col_out_q[2];
	assign white = col_out_q[3];
	assign update_strobe = strobe_out_q;
	assign run_last = last_out_q;

endmodule

// ===== hw/rtl/dtpm_ctrl.sv =====
// Controller: sequences accept, multiply and write emission per item.
// Depends on dtpm_pkg.
`timescale 1ns / 1ps

module dtpm_ctrl
	import dtpm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_MUL;
						ready_q <= 1'b0;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!sts.any || (sts.out_free && sts.last)) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;
	assign cmd.accept = in_valid && ready_q;
	assign cmd.mul = (state_q == ST_MUL);
	assign cmd.load = (state_q == ST_EMIT) && sts.any && sts.out_free;

endmodule

// ===== hw/rtl/dmx_to_pixel_mapper_top.sv =====
// Path: an item is registered on accept, its group position is multiplied, and the emission
// loop then loads its results into the output register, one write per cycle unless the output
// stalls. No new item is accepted until the previous one has left the emission loop.
// Reset: arst_n clears the controller, pixel assembly state and output valid, and loads
// the register defaults (3 channels, RGB, 1 universe, 170 groups, grouping 1).
// Top level: configuration registers, controller and datapath. Depends on dtpm_pkg.
`timescale 1ns / 1ps
`include "dmx_to_pixel_mapper_top_defines.svh"

module dmx_to_pixel_mapper_top
	import dtpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // channel_byte
	input  logic [6:0]  s_axis_tuser,   // port_index[4:0], frame_first, want_update
	input  logic        s_axis_tlast,   // frame_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// output_number[2:0], pixel_number[14:3], red, green, blue, white, zero pad [47]
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // write_valid, update_strobe
	output logic        m_axis_tlast,   // run_last
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	cfg_t        cfg_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        write_valid;
	logic [2:0]  output_number;
	logic [11:0] pixel_number;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  white;
	logic        update_strobe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CPP:         cfg_q.cpp <= cfg_wdata[2:0];
				REG_COLOR_MAP:   cfg_q.color_map <= cfg_wdata[2:0];
				REG_UNIVERSES:   cfg_q.universes <= cfg_wdata[2:0];
				REG_GROUP_COUNT: cfg_q.group_count <= cfg_wdata[12:0];
				REG_GROUPING:    cfg_q.grouping <= cfg_wdata[6:0];
				REG_LAST_PORT:   cfg_q.last_port <= cfg_wdata[4:0];
				REG_BEGIN_TABLE: cfg_q.begin_table <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dtpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dtpm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.port_index    (s_axis_tuser[4:0]),
		.channel_byte  (s_axis_tdata),
		.frame_first   (s_axis_tuser[5]),
		.frame_last    (s_axis_tlast),
		.want_update   (s_axis_tuser[6]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.write_valid   (write_valid),
		.output_number (output_number),
		.pixel_number  (pixel_number),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.white         (white),
		.update_strobe (update_strobe),
		.run_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, white, blue, green, red, pixel_number, output_number};
	assign m_axis_tuser = {update_strobe, write_valid};

	`DTPM_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "input taken while an item is still in work")
	`DTPM_ASSERT_NOW(a_empty_result_is_strobe, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tuser[1] && m_axis_tlast, "non-write result without strobe and last")
	`DTPM_ASSERT_NOW(a_strobe_on_last, m_axis_tvalid && m_axis_tuser[1],
		m_axis_tlast, "update strobe on a result that is not the last of its run")

endmodule
